// File: rtl/tsq_pkg.sv
// tsq_pkg: shared types and constants for the tone sequencer.
// Item structs, mode codes, field widths and fixed-point constants.
// No dependencies.
package tsq_pkg;

  localparam int MAX_NOTES_DEF       = 16;
  localparam int SAMPLE_RATE_DEF     = 16000;
  localparam int SINE_TABLE_SIZE_DEF = 1024;
  localparam int PHASE_BITS_DEF      = 32;

  localparam int MODE_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int HZ_W     = 16;
  localparam int MS_W     = 16;
  localparam int SEQ_W    = 8;
  localparam int LOUD_W   = 8;
  localparam int SAMPLE_W = 14;

  localparam int VOL_W       = 7;
  localparam int VOL_MAX     = 100;
  localparam int VOL_RESET   = 60;
  localparam int AMP_PER_VOL = 80;
  localparam int AMP_W       = 13;
  localparam int MAG_W       = 15;
  localparam int MAG_MAX     = 32767;
  localparam int MS_PER_S    = 1000;
  localparam int MS_MAX      = 65535;
  localparam int RAMP_MS     = 3;
  localparam int IDLE_W      = 17;
  localparam int IDLE_LIMIT  = 80000;
  localparam int Q15_SHIFT   = 15;
  localparam int Q28_SHIFT   = 28;

  localparam longint unsigned HALF_PI_Q28 = 64'd421657428;
  localparam longint unsigned ONE_Q28     = 64'd1 << Q28_SHIFT;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 0,
    MODE_START = 1,
    MODE_STOP  = 2,
    MODE_TICK  = 3
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [SLOT_W-1:0]  note_slot;
    logic [HZ_W-1:0]    tone_hz;
    logic [MS_W-1:0]    length_ms;
    logic [SEQ_W-1:0]   sequence_length;
    logic [LOUD_W-1:0]  loudness;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       busy_res;
    logic                       amp_on;
    logic                       accepted;
  } out_item_t;

endpackage

// File: rtl/tsq_stream_if.sv
// tsq_stream_if: valid/ready channel carrying one item per handshake.
// Payload type is a parameter (tsq_pkg::in_item_t or tsq_pkg::out_item_t).
interface tsq_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/tsq_ram.sv
// tsq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/tsq_sdiv.sv
// tsq_sdiv: bit-serial restoring divider, one quotient bit per cycle.
// Quotient held until the next start.
module tsq_sdiv #(
  parameter int DW = 48,
  parameter int VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);
  localparam int CNTW = $clog2(DW);

  logic            run_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   sh_q;
  logic [VW-1:0]   rem_q, div_q;
  logic [VW:0]     trial, diff;
  logic            ge;

  assign trial = {rem_q, sh_q[DW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (run_q) begin
        cnt_q <= cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(DW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      sh_q  <= {sh_q[DW-2:0], ge};
      rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;
endmodule

// File: rtl/tsq_smul.sv
// tsq_smul: bit-serial shift-add multiplier, one multiplier bit per cycle.
// Product held until the next start.
module tsq_smul #(
  parameter int MA = 28,
  parameter int MB = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MA-1:0]    a_i,
  input  logic [MB-1:0]    b_i,
  output logic             done_o,
  output logic [MA+MB-1:0] prod_o
);
  localparam int CNTW = $clog2(MB);

  logic             run_q, done_q;
  logic [CNTW-1:0]  cnt_q;
  logic [MA-1:0]    a_q;
  logic [MA+MB-1:0] p_q;
  logic [MA:0]      sum;

  assign sum = {1'b0, p_q[MA+MB-1:MB]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (run_q) begin
        cnt_q <= cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(MB - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{MA{1'b0}}, b_i};
    end else if (run_q) begin
      p_q <= {sum, p_q[MB-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;
endmodule

// File: rtl/tone_sequencer_with_envelope.sv
// tone_sequencer_with_envelope: note queue player with DDS sine and linear envelope.
// One item at a time; the next item is taken on return to idle while a result waits.
// Start/stop pass straight to the result; load runs two serial divides.
// Tick: serial multiplies then divide by the ramp; rests and idle ticks skip the arithmetic,
//   and each zero-length note is passed over first.
// Reset clears queue, counters, phase, amp enable; volume 60; note store undefined until loaded.
module tone_sequencer_with_envelope #(
  parameter int MAX_NOTES       = tsq_pkg::MAX_NOTES_DEF,
  parameter int SAMPLE_RATE     = tsq_pkg::SAMPLE_RATE_DEF,
  parameter int SINE_TABLE_SIZE = tsq_pkg::SINE_TABLE_SIZE_DEF,
  parameter int PHASE_BITS      = tsq_pkg::PHASE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tsq_stream_if.sink   in_i,
  tsq_stream_if.source out_o
);
  import tsq_pkg::*;

  localparam int CW   = $clog2(MAX_NOTES + 1);
  localparam int AW   = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int RAMP = SAMPLE_RATE * RAMP_MS / MS_PER_S;
  localparam int RW   = $clog2(RAMP + 1);
  localparam longint unsigned TOTAL_MAX =
    (64'(SAMPLE_RATE) * 64'(MS_MAX)) / 64'(MS_PER_S);
  localparam int TW   = $clog2(TOTAL_MAX + 1);
  localparam int SRW  = $clog2(SAMPLE_RATE + 1);
  localparam int VW   = SRW;
  localparam int DW   = HZ_W + PHASE_BITS;
  localparam int PW   = SRW + MS_W;
  localparam int MA   = MAG_W + AMP_W;
  localparam int MB   = (AMP_W > RW) ? AMP_W : RW;
  localparam int TB   = $clog2(SINE_TABLE_SIZE);
  localparam int NW   = TB + 2;
  localparam int PIW  = PHASE_BITS + TB + 1;
  localparam int QN   = SINE_TABLE_SIZE / 4 + 1;
  localparam int QW   = $clog2(QN);
  localparam int EW   = 1 + PHASE_BITS + TW;

  localparam logic [3:0] ST_IDLE  = 4'd0,
                         ST_DISP  = 4'd1,
                         ST_LD1   = 4'd2,
                         ST_LD2   = 4'd3,
                         ST_TRD   = 4'd4,
                         ST_TCHK  = 4'd5,
                         ST_TSIN  = 4'd6,
                         ST_TMUL1 = 4'd7,
                         ST_TMUL2 = 4'd8,
                         ST_TDIV  = 4'd9,
                         ST_TUPD  = 4'd10,
                         ST_FIN   = 4'd11;

  // quarter-wave magnitude table, entry k is the sine at quarter position 4k
  typedef logic [MAG_W-1:0] qtab_t [QN];

  function automatic qtab_t build_qtab();
    qtab_t tab;
    longint unsigned x, x2, t, s, v;
    for (int k = 0; k < QN; k++) begin
      x  = (64'(4 * k) * HALF_PI_Q28) / 64'(SINE_TABLE_SIZE);
      x2 = (x * x) >> Q28_SHIFT;
      // odd Taylor series to x^9, Horner form
      t  = ONE_Q28 - x2 / 64'd72;
      t  = ONE_Q28 - ((x2 * t) >> Q28_SHIFT) / 64'd42;
      t  = ONE_Q28 - ((x2 * t) >> Q28_SHIFT) / 64'd20;
      t  = ONE_Q28 - ((x2 * t) >> Q28_SHIFT) / 64'd6;
      s  = (x * t) >> Q28_SHIFT;
      v  = (s * 64'(MAG_MAX) + (64'd1 << (Q28_SHIFT - 1))) >> Q28_SHIFT;
      if (v > 64'(MAG_MAX)) begin
        v = 64'(MAG_MAX);
      end
      tab[k] = MAG_W'(v);
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic [3:0]            state_q, state_d;
  in_item_t              item_q, item_d;
  logic [CW-1:0]         queued_q, queued_d, cur_q, cur_d;
  logic [VOL_W-1:0]      vol_q, vol_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d, step_q, step_d;
  logic [TW-1:0]         sidx_q, sidx_d, total_q, total_d;
  logic [IDLE_W-1:0]     idle_q, idle_d, idle_inc;
  logic                  amp_q, amp_d, acc_q, acc_d, neg_q, neg_d;
  logic [RW-1:0]         envn_q, envn_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic                  ov_q, ov_d;
  out_item_t             od_q, od_d;

  logic                  div_start, div_done;
  logic [DW-1:0]         div_dividend, div_quot;
  logic [VW-1:0]         div_divisor;
  logic                  mul_start, mul_done;
  logic [MA-1:0]         mul_a;
  logic [MB-1:0]         mul_b;
  logic [MA+MB-1:0]      mul_prod;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [EW-1:0]         ram_wdata, ram_rdata;

  logic                  e_nz;
  logic [PHASE_BITS-1:0] e_step;
  logic [TW-1:0]         e_total, e_diff, sidx_inc;
  logic [PW-1:0]         ld_prod;
  logic [AMP_W-1:0]      amp_val;
  logic [PIW-1:0]        idx_full;
  logic [TB-1:0]         tab_idx;
  logic [NW-1:0]         n4, r_pos;
  logic [1:0]            quad;
  logic [MAG_W-1:0]      mag;
  logic [SAMPLE_W-1:0]   qmag;
  logic                  slot_ok;

  tsq_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_NOTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tsq_sdiv #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  tsq_smul #(
    .MA (MA),
    .MB (MB)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign e_nz     = ram_rdata[EW-1];
  assign e_step   = ram_rdata[TW +: PHASE_BITS];
  assign e_total  = ram_rdata[TW-1:0];
  assign e_diff   = e_total - sidx_q;
  assign sidx_inc = sidx_q + TW'(1);
  assign ld_prod  = PW'(SAMPLE_RATE) * PW'(item_q.length_ms);
  assign amp_val  = AMP_W'(AMP_PER_VOL) * AMP_W'(vol_q);
  assign idle_inc = (idle_q == {IDLE_W{1'b1}}) ? idle_q : idle_q + IDLE_W'(1);
  assign slot_ok  = 32'(item_q.note_slot) < 32'(MAX_NOTES);
  assign qmag     = div_quot[SAMPLE_W-1:0];

  // table index and quarter-wave fold
  always_comb begin
    idx_full = PIW'(phase_q) * PIW'(SINE_TABLE_SIZE);
    tab_idx  = idx_full[PHASE_BITS +: TB];
    n4       = {tab_idx, 2'b00};
    if (n4 >= NW'(3 * SINE_TABLE_SIZE)) begin
      quad  = 2'd3;
      r_pos = n4 - NW'(3 * SINE_TABLE_SIZE);
    end else if (n4 >= NW'(2 * SINE_TABLE_SIZE)) begin
      quad  = 2'd2;
      r_pos = n4 - NW'(2 * SINE_TABLE_SIZE);
    end else if (n4 >= NW'(SINE_TABLE_SIZE)) begin
      quad  = 2'd1;
      r_pos = n4 - NW'(SINE_TABLE_SIZE);
    end else begin
      quad  = 2'd0;
      r_pos = n4;
    end
    if (quad[0]) begin
      r_pos = NW'(SINE_TABLE_SIZE) - r_pos;
    end
    mag = QTAB[QW'(r_pos >> 2)];
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    queued_d     = queued_q;
    cur_d        = cur_q;
    vol_d        = vol_q;
    phase_d      = phase_q;
    step_d       = step_q;
    sidx_d       = sidx_q;
    total_d      = total_q;
    idle_d       = idle_q;
    amp_d        = amp_q;
    acc_d        = acc_q;
    neg_d        = neg_q;
    envn_d       = envn_q;
    sample_d     = sample_q;
    ov_d         = ov_q & ~out_o.ready;
    od_d         = od_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = AW'(item_q.note_slot);
    ram_wdata    = {item_q.tone_hz != '0, step_q, div_quot[TW-1:0]};
    ram_raddr    = AW'(cur_q);

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          item_d  = in_i.data;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        sample_d = '0;
        acc_d    = 1'b0;
        state_d  = ST_FIN;
        unique case (item_q.mode)
          MODE_LOAD: begin
            div_start    = 1'b1;
            div_dividend = {item_q.tone_hz, {PHASE_BITS{1'b0}}};
            div_divisor  = VW'(SAMPLE_RATE);
            state_d      = ST_LD1;
          end
          MODE_START: begin
            if (item_q.sequence_length != '0) begin
              queued_d = (32'(item_q.sequence_length) > 32'(MAX_NOTES)) ?
                         CW'(MAX_NOTES) : CW'(item_q.sequence_length);
              cur_d    = '0;
              sidx_d   = '0;
              vol_d    = (item_q.loudness > LOUD_W'(VOL_MAX)) ?
                         VOL_W'(VOL_MAX) : item_q.loudness[VOL_W-1:0];
              amp_d    = 1'b1;
              idle_d   = '0;
              acc_d    = 1'b1;
            end
          end
          MODE_STOP: begin
            queued_d = '0;
            cur_d    = '0;
            sidx_d   = '0;
          end
          MODE_TICK: begin
            state_d = ST_TRD;
          end
          default: ;
        endcase
      end
      ST_LD1: begin
        if (div_done) begin
          step_d       = div_quot[PHASE_BITS-1:0];
          div_start    = 1'b1;
          div_dividend = DW'(ld_prod);
          div_divisor  = VW'(MS_PER_S);
          state_d      = ST_LD2;
        end
      end
      ST_LD2: begin
        if (div_done) begin
          ram_we  = slot_ok;
          state_d = ST_FIN;
        end
      end
      ST_TRD: begin
        if (cur_q < queued_q) begin
          ram_re  = 1'b1;
          state_d = ST_TCHK;
        end else begin
          if (amp_q) begin
            if (idle_inc > IDLE_W'(IDLE_LIMIT)) begin
              amp_d  = 1'b0;
              idle_d = '0;
            end else begin
              idle_d = idle_inc;
            end
          end
          state_d = ST_FIN;
        end
      end
      ST_TCHK: begin
        if (e_total <= sidx_q) begin
          cur_d   = cur_q + CW'(1);
          sidx_d  = '0;
          state_d = ST_TRD;
        end else begin
          step_d  = e_step;
          total_d = e_total;
          if (sidx_q < TW'(RAMP)) begin
            envn_d = RW'(sidx_q);
          end else if (e_diff < TW'(RAMP)) begin
            envn_d = RW'(e_diff);
          end else begin
            envn_d = RW'(RAMP);
          end
          state_d = e_nz ? ST_TSIN : ST_TUPD;
        end
      end
      ST_TSIN: begin
        neg_d     = quad[1];
        mul_start = 1'b1;
        mul_a     = MA'(mag);
        mul_b     = MB'(amp_val);
        state_d   = ST_TMUL1;
      end
      ST_TMUL1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_prod[MA-1:0];
          mul_b     = MB'(envn_q);
          state_d   = ST_TMUL2;
        end
      end
      ST_TMUL2: begin
        if (mul_done) begin
          div_start    = 1'b1;
          div_dividend = DW'(mul_prod[MA+MB-1:Q15_SHIFT]);
          div_divisor  = VW'(RAMP);
          state_d      = ST_TDIV;
        end
      end
      ST_TDIV: begin
        if (div_done) begin
          sample_d = neg_q ? -$signed(qmag) : $signed(qmag);
          state_d  = ST_TUPD;
        end
      end
      ST_TUPD: begin
        phase_d = phase_q + step_q;
        idle_d  = '0;
        if (sidx_inc >= total_q) begin
          cur_d  = cur_q + CW'(1);
          sidx_d = '0;
        end else begin
          sidx_d = sidx_inc;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!ov_q || out_o.ready) begin
          ov_d          = 1'b1;
          od_d.sample   = sample_q;
          od_d.busy_res = cur_q < queued_q;
          od_d.amp_on   = amp_q;
          od_d.accepted = acc_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      queued_q <= '0;
      cur_q    <= '0;
      vol_q    <= VOL_W'(VOL_RESET);
      phase_q  <= '0;
      sidx_q   <= '0;
      idle_q   <= '0;
      amp_q    <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      queued_q <= queued_d;
      cur_q    <= cur_d;
      vol_q    <= vol_d;
      phase_q  <= phase_d;
      sidx_q   <= sidx_d;
      idle_q   <= idle_d;
      amp_q    <= amp_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    step_q   <= step_d;
    total_q  <= total_d;
    acc_q    <= acc_d;
    neg_q    <= neg_d;
    envn_q   <= envn_d;
    sample_q <= sample_d;
    od_q     <= od_d;
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign out_o.valid = ov_q;
  assign out_o.data  = od_q;

  a_cur_in_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= queued_q)
    else $error("note pointer past end of queue");

  a_vol_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vol_q <= VOL_W'(VOL_MAX))
    else $error("volume above clamp");

  a_idle_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !amp_q |-> idle_q == '0)
    else $error("idle count nonzero with amp off");

  a_idle_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q <= IDLE_W'(IDLE_LIMIT))
    else $error("idle count past limit");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q) == ST_FIN)
    else $error("result item raised outside final step");
endmodule
